// ----- rtl/sabc_pkg.sv -----
// Shared codes and types of the strided access bounds checker.
package sabc_pkg;

  localparam int FIELD_W    = 64;
  localparam int NREC_W     = 31;
  localparam int IN_DATA_W  = 288;
  localparam int IN_USER_W  = 7;
  localparam int OUT_DATA_W = 8;
  localparam int STATUS_W   = 3;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_COORD  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EDGE       = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NEG_COUNT  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BAD_STRIDE = 3'd4;

  localparam logic [1:0] EDGE_NONE      = 2'd0;
  localparam logic [1:0] EDGE_EXCEEDED  = 2'd1;
  localparam logic [1:0] EDGE_NEG_COUNT = 2'd2;

  localparam logic [1:0] API_WHOLE   = 2'd0;
  localparam logic [1:0] API_ELEMENT = 2'd1;
  localparam logic [1:0] API_ARRAY   = 2'd2;
  localparam logic [1:0] API_STRIDED = 2'd3;

  localparam logic [0:0] REG_RELAXED = 1'd0;
  localparam logic [0:0] REG_CLASSIC = 1'd1;

  // Largest record start allowed by the classic file format.
  localparam logic [32:0] CLASSIC_START_MAX = 33'h0_FFFF_FFFF;

  typedef struct packed {
    logic relaxed;
    logic classic;
  } cfg_t;

  // Classification of one dimension, handed from the front end to the back end.
  typedef struct packed {
    logic       scalar;
    logic       last;
    logic [1:0] api;
    logic       step_given;
    logic       span_given;
    logic       coord_err;
    logic       stride_err;
    logic       need_li;
    logic [1:0] edge_pre;
    logic       stride_neg;
  } cls_flags_t;

endpackage

// ----- rtl/sabc_front.sv -----
// Front end: classifies one dimension with compares and prepares the multiply operands.
module sabc_front #(
  parameter int W = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  sabc_pkg::cfg_t                  cfg,
  input  logic                            scalar_request,
  input  logic [1:0]                      api_kind,
  input  logic                            is_read,
  input  logic [sabc_pkg::NREC_W-1:0]     num_records,
  input  logic [sabc_pkg::FIELD_W-1:0]    extent,
  input  logic [sabc_pkg::FIELD_W-1:0]    origin,
  input  logic [sabc_pkg::FIELD_W-1:0]    span,
  input  logic [sabc_pkg::FIELD_W-1:0]    step_size,
  input  logic                            origin_given,
  input  logic                            span_given,
  input  logic                            step_given,
  input  logic                            last_dim,
  output sabc_pkg::cls_flags_t            flags,
  output logic [W-1:0]                    mul_a,
  output logic [W-1:0]                    mul_b,
  output logic [W-1:0]                    org_out,
  output logic [W-1:0]                    bound_out
);
  import sabc_pkg::*;

  logic               at_first;
  logic signed [W-1:0] ext, org, cnt, stp, bound;
  logic signed [W:0]   org_x, start_lim, sum, bound_x;
  logic               rec_dim, check, cnt_pos, org_lt, org_eq;
  logic               coord;
  logic [1:0]         edge_pre;
  logic               need_li;

  // The first dimension of a request follows a scalar request or a last dimension.
  always_ff @(posedge clk) begin
    if (rst) begin
      at_first <= 1'b1;
    end else if (accept) begin
      at_first <= scalar_request | last_dim;
    end
  end

  assign ext = extent[W-1:0];
  assign org = origin[W-1:0];
  assign cnt = span[W-1:0];
  assign stp = step_size[W-1:0];

  assign rec_dim   = at_first && (ext == '0);
  assign bound     = rec_dim ? W'(num_records) : ext;
  assign check     = !rec_dim || is_read;
  assign cnt_pos   = !cnt[W-1] && (cnt != '0);
  assign org_lt    = org < bound;
  assign org_eq    = org == bound;
  assign org_x     = {org[W-1], org};
  assign start_lim = (W+1)'(CLASSIC_START_MAX);
  assign sum       = {org[W-1], org} + {cnt[W-1], cnt};
  assign bound_x   = {bound[W-1], bound};

  always_comb begin
    coord = 1'b0;
    if (!origin_given || org[W-1]) begin
      coord = 1'b1;
    end else if (rec_dim && cfg.classic && (org_x > start_lim)) begin
      coord = 1'b1;
    end else if (check) begin
      if (cfg.relaxed) begin
        if (!org_lt && !org_eq) begin
          coord = 1'b1;
        end else if (org_eq && ((api_kind == API_ELEMENT) || (span_given && cnt_pos))) begin
          coord = 1'b1;
        end
      end else if (!org_lt) begin
        coord = 1'b1;
      end
    end
  end

  // The strided bound needs the product, so it is only flagged here.
  always_comb begin
    edge_pre = EDGE_NONE;
    need_li  = 1'b0;
    if (!rec_dim && ext[W-1]) begin
      edge_pre = EDGE_EXCEEDED;
    end else if (cnt[W-1]) begin
      edge_pre = EDGE_NEG_COUNT;
    end else if (check) begin
      if (!step_given) begin
        if ((!rec_dim && (cnt > bound)) || (sum > bound_x)) begin
          edge_pre = EDGE_EXCEEDED;
        end
      end else if (cnt_pos) begin
        need_li = 1'b1;
      end
    end
  end

  assign flags.scalar     = scalar_request;
  assign flags.last       = last_dim;
  assign flags.api        = api_kind;
  assign flags.step_given = step_given;
  assign flags.span_given = span_given;
  assign flags.coord_err  = coord;
  assign flags.stride_err = step_given && (stp[W-1] || (stp == '0));
  assign flags.need_li    = need_li;
  assign flags.edge_pre   = edge_pre;
  assign flags.stride_neg = stp[W-1];

  assign mul_a     = cnt - W'(1);
  assign mul_b     = stp[W-1] ? (W'(0) - stp) : stp;
  assign org_out   = org;
  assign bound_out = bound;

endmodule

// ----- rtl/sabc_queue.sv -----
// Short first-in first-out queue between the front end and the back end.
module sabc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign pop_data = mem[rd_ptr];
  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;

endmodule

// ----- rtl/sabc_back.sv -----
// Back end: exact last-index pipeline, per-request error flags and the status register.
module sabc_back #(
  parameter int W = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  sabc_pkg::cls_flags_t          q_flags,
  input  logic [W-1:0]                  q_a,
  input  logic [W-1:0]                  q_b,
  input  logic [W-1:0]                  q_org,
  input  logic [W-1:0]                  q_bound,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sabc_pkg::STATUS_W-1:0] status
);
  import sabc_pkg::*;

  localparam int H  = (W + 1) / 2;
  localparam int HW = W - H;

  typedef struct packed {
    cls_flags_t   flags;
    logic [W-1:0] org;
    logic [W-1:0] bound;
  } side_t;

  logic              adv;
  logic              s1_valid, s2_valid, s3_valid, s4_valid;
  side_t             s1_side, s2_side, s3_side, s4_side;
  logic [2*H-1:0]    s1_p00;
  logic [W-1:0]      s1_p01, s1_p10;
  logic [2*HW-1:0]   s1_p11;
  logic [W:0]        s2_mid;
  logic [2*W-1:0]    s2_cat;
  logic [2*W-1:0]    s3_prod;
  logic signed [2*W:0] s4_li;

  logic [H-1:0]      a_lo, b_lo;
  logic [HW-1:0]     a_hi, b_hi;
  logic signed [2*W:0] org_x, prod_x, bound_x;

  logic              coord_seen, stride_seen;
  logic [1:0]        edge_code;
  logic              li_ge;
  logic [1:0]        item_edge;
  logic              coord_next, stride_next;
  logic [1:0]        edge_next;
  logic [STATUS_W-1:0] status_next;
  logic              emit;

  // The whole pipeline moves together; it freezes only while a result waits.
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && q_valid;

  assign a_lo = q_a[H-1:0];
  assign a_hi = q_a[W-1:H];
  assign b_lo = q_b[H-1:0];
  assign b_hi = q_b[W-1:H];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= q_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Four half-width partial products, then their sum, then the signed offset from the start.
  assign org_x  = {{(W+1){s3_side.org[W-1]}}, s3_side.org};
  assign prod_x = {1'b0, s3_prod};

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side <= '{flags: q_flags, org: q_org, bound: q_bound};
      s1_p00  <= {{H{1'b0}}, a_lo} * {{H{1'b0}}, b_lo};
      s1_p01  <= {{HW{1'b0}}, a_lo} * {{H{1'b0}}, b_hi};
      s1_p10  <= {{H{1'b0}}, a_hi} * {{HW{1'b0}}, b_lo};
      s1_p11  <= {{HW{1'b0}}, a_hi} * {{HW{1'b0}}, b_hi};
      s2_side <= s1_side;
      s2_mid  <= {1'b0, s1_p01} + {1'b0, s1_p10};
      s2_cat  <= {s1_p11, s1_p00};
      s3_side <= s2_side;
      s3_prod <= s2_cat + ((2*W)'(s2_mid) << H);
      s4_side <= s3_side;
      s4_li   <= s3_side.flags.stride_neg ? (org_x - prod_x) : (org_x + prod_x);
    end
  end

  assign bound_x = {{(W+1){s4_side.bound[W-1]}}, s4_side.bound};
  assign li_ge   = s4_li >= bound_x;

  always_comb begin
    item_edge   = s4_side.flags.need_li ? (li_ge ? EDGE_EXCEEDED : EDGE_NONE)
                                        : s4_side.flags.edge_pre;
    coord_next  = coord_seen | s4_side.flags.coord_err;
    stride_next = stride_seen | s4_side.flags.stride_err;
    if (!s4_side.flags.span_given) begin
      edge_next = EDGE_EXCEEDED;
    end else if (edge_code == EDGE_NONE) begin
      edge_next = item_edge;
    end else begin
      edge_next = edge_code;
    end

    // Phase priority: coordinates, then edges and counts, then strides.
    if (s4_side.flags.scalar || (s4_side.flags.api == API_WHOLE)) begin
      status_next = STATUS_OK;
    end else if (coord_next) begin
      status_next = STATUS_BAD_COORD;
    end else if (s4_side.flags.api == API_ELEMENT) begin
      status_next = STATUS_OK;
    end else if (edge_next == EDGE_NEG_COUNT) begin
      status_next = STATUS_NEG_COUNT;
    end else if (edge_next != EDGE_NONE) begin
      status_next = STATUS_EDGE;
    end else if ((s4_side.flags.api != API_STRIDED) || !s4_side.flags.step_given) begin
      status_next = STATUS_OK;
    end else begin
      status_next = stride_next ? STATUS_BAD_STRIDE : STATUS_OK;
    end
  end

  assign emit = s4_side.flags.scalar || s4_side.flags.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_seen  <= 1'b0;
      stride_seen <= 1'b0;
      edge_code   <= EDGE_NONE;
      out_valid   <= 1'b0;
    end else if (adv) begin
      out_valid <= s4_valid && emit;
      if (s4_valid) begin
        if (emit) begin
          coord_seen  <= 1'b0;
          stride_seen <= 1'b0;
          edge_code   <= EDGE_NONE;
        end else begin
          coord_seen  <= coord_next;
          stride_seen <= stride_next;
          edge_code   <= edge_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status <= status_next;
    end
  end

endmodule

// ----- rtl/strided_access_bounds_checker_top.sv -----
// Top level of the strided access bounds checker: ports, configuration and wiring.
//
//   channel  | direction | handshake                      | payload
//   ---------+-----------+--------------------------------+-------------------------------
//   s_axis   | in        | s_axis_tvalid / s_axis_tready  | one dimension per item
//   m_axis   | out       | m_axis_tvalid / m_axis_tready  | one status per request
//   cfg      | in        | cfg_we                         | relaxed_bounds, classic_format
//
// One dimension is accepted every cycle while the queue is not full; the item ending a request
// passes through the queue, then the four registers s1 to s4 of the half-width multiply and add
// pipeline, and its status is then loaded into the status register.
// Reset clears the queue, the pipeline, the request flags and both configuration bits.
// While a status waits on m_axis the back end holds still and the queue of QUEUE_DEPTH
// items keeps taking input; s_axis_tready falls only once the queue is full.
module strided_access_bounds_checker_top #(
  parameter int OFFSET_BITS = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // num_records[30:0], extent[94:31], origin[158:95], span[222:159], step_size[286:223]
  input  logic [sabc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // scalar_request[0], api_kind[2:1], is_read[3], origin_given[4], span_given[5],
  // step_given[6]
  input  logic [sabc_pkg::IN_USER_W-1:0]    s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status[2:0]
  output logic [sabc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [0:0]                        cfg_data
);
  import sabc_pkg::*;

  localparam int W  = OFFSET_BITS;
  localparam int QW = $bits(cls_flags_t) + 4 * W;

  cfg_t            cfg;
  cls_flags_t      f_flags, q_flags;
  logic [W-1:0]    f_a, f_b, f_org, f_bound;
  logic [W-1:0]    q_a, q_b, q_org, q_bound;
  logic [QW-1:0]   q_in, q_out;
  logic            q_push, q_pop, q_full, q_empty;
  logic [STATUS_W-1:0] status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RELAXED: cfg.relaxed <= cfg_data[0];
        REG_CLASSIC: cfg.classic <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  sabc_front #(.W(W)) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (q_push),
    .cfg            (cfg),
    .scalar_request (s_axis_tuser[0]),
    .api_kind       (s_axis_tuser[2:1]),
    .is_read        (s_axis_tuser[3]),
    .num_records    (s_axis_tdata[30:0]),
    .extent         (s_axis_tdata[94:31]),
    .origin         (s_axis_tdata[158:95]),
    .span           (s_axis_tdata[222:159]),
    .step_size      (s_axis_tdata[286:223]),
    .origin_given   (s_axis_tuser[4]),
    .span_given     (s_axis_tuser[5]),
    .step_given     (s_axis_tuser[6]),
    .last_dim       (s_axis_tlast),
    .flags          (f_flags),
    .mul_a          (f_a),
    .mul_b          (f_b),
    .org_out        (f_org),
    .bound_out      (f_bound)
  );

  assign q_in = {f_flags, f_a, f_b, f_org, f_bound};

  sabc_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {q_flags, q_a, q_b, q_org, q_bound} = q_out;

  sabc_back #(.W(W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_empty),
    .q_flags   (q_flags),
    .q_a       (q_a),
    .q_b       (q_b),
    .q_org     (q_org),
    .q_bound   (q_bound),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - STATUS_W){1'b0}}, status};

  // A waiting status must freeze the back end, so nothing leaves the queue.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !q_pop)
    else $error("queue popped while a status was stalled");

  assert property (@(posedge clk) disable iff (rst) q_empty |-> !q_pop)
    else $error("pop from an empty queue");

  assert property (@(posedge clk) disable iff (rst)
    (q_full && !q_pop) |=> q_full)
    else $error("queue lost an item without a pop");

  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("status valid straight after reset");

endmodule
